[hw/rtl/dynamic_priority_scheduler_assert.svh]
// assertion macros for the dynamic priority scheduler
// expects clk and rst_n in the scope of the including module
`ifndef DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH
`define DYNAMIC_PRIORITY_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DPS_ASSERT_IMPLY(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define DPS_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define DPS_ASSERT_IMPLY(lbl, a, c, msg)
`define DPS_ASSERT_NEXT(lbl, a, c, msg)
`endif
`endif

[hw/rtl/dps_pkg.sv]
// shared types and constants of the dynamic priority scheduler
// no dependencies
`default_nettype none
package dps_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int BASE_W  = 15;
  localparam int SLICE_W = 8;
  localparam int STEP_W  = 8;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 2;

  localparam logic [BASE_W-1:0]  BASE_RST  = 15'd50;
  localparam logic [SLICE_W-1:0] SLICE_RST = 8'd2;
  localparam logic [STEP_W-1:0]  STEP_RST  = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd2;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [16:0] PRI_MIN = -17'sd32768;

  typedef enum logic [2:0] {
    ST_ADDED = 3'd0,
    ST_FULL  = 3'd1,
    ST_RUN   = 3'd2,
    ST_FIN   = 3'd3,
    ST_EMPTY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [16:0] pri;
    logic [15:0]        need;
    logic [15:0]        cpu;
    logic [15:0]        runs;
  } entry_t;

  typedef struct packed {
    logic start;
    logic beat;
    logic occ;
  } pick_ctl_t;

  typedef struct packed {
    logic found;
    logic free_found;
  } pick_st_t;

endpackage
`default_nettype wire

[hw/rtl/dps_in_if.sv]
// command channel of the scheduler
// no dependencies
`default_nettype none
interface dps_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  process_id;
  logic [15:0] need_time;

  modport source (output valid, command, process_id, need_time, input ready);
  modport sink (input valid, command, process_id, need_time, output ready);
endinterface
`default_nettype wire

[hw/rtl/dps_out_if.sv]
// result channel of the scheduler
// no dependencies
`default_nettype none
interface dps_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [7:0]         chosen_id;
  logic [15:0]        cpu_used;
  logic [15:0]        need_left;
  logic [15:0]        run_count;
  logic signed [15:0] new_priority;

  modport source (output valid, status, chosen_id, cpu_used, need_left, run_count,
                  new_priority, input ready);
  modport sink (input valid, status, chosen_id, cpu_used, need_left, run_count,
                new_priority, output ready);
endinterface
`default_nettype wire

[hw/rtl/dps_pick.sv]
// shared compare unit: tracks best entry and lowest free slot over a table scan
// depends on dps_pkg
`default_nettype none
module dps_pick #(
  parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF,
  localparam int IDX_W = $clog2(MAX_PROCS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dps_pkg::pick_ctl_t ctl,
  input  wire logic [IDX_W-1:0]   beat_idx,
  input  wire dps_pkg::entry_t    beat_ent,
  output dps_pkg::pick_st_t       st,
  output logic [IDX_W-1:0]        best_idx,
  output logic [IDX_W-1:0]        free_idx,
  output dps_pkg::entry_t         best_ent
);

  logic             found_r;
  logic             free_found_r;
  logic [IDX_W-1:0] best_idx_r;
  logic [IDX_W-1:0] free_idx_r;
  dps_pkg::entry_t  best_ent_r;
  logic             better;
  logic             take_best;
  logic             take_free;

  always_comb begin
    better = !found_r
          || ($signed(beat_ent.pri) > $signed(best_ent_r.pri))
          || (($signed(beat_ent.pri) == $signed(best_ent_r.pri))
              && (beat_ent.id > best_ent_r.id));
    take_best = ctl.beat && ctl.occ && better;
    take_free = ctl.beat && !ctl.occ && !free_found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else if (ctl.start) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (take_best) begin
        found_r <= 1'b1;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_ent_r <= beat_ent;
      best_idx_r <= beat_idx;
    end
    if (take_free) begin
      free_idx_r <= beat_idx;
    end
  end

  assign st.found      = found_r;
  assign st.free_found = free_found_r;
  assign best_idx      = best_idx_r;
  assign free_idx      = free_idx_r;
  assign best_ent      = best_ent_r;

endmodule
`default_nettype wire

[hw/rtl/dynamic_priority_scheduler.sv]
// top level of the dynamic priority scheduler: sequencer, entry memory, update
// depends on dps_pkg, dps_in_if, dps_out_if, dps_pick and the assertion header
//
// channel   dir  beat contents
// in_ch     in   command, process_id, need_time
// out_ch    out  status, chosen_id, cpu_used, need_left, run_count, new_priority
// cfg_*     in   one register write per cycle, no handshake
//
// every command walks all MAX_PROCS slots, one memory read per cycle
// through the shared compare unit, then commits at most one slot
// the next command is accepted only once the sequencer is back in idle
// the result register holds a beat until taken; commit waits while it is full and not taken
// reset clears the valid bits and restores the config defaults; no clearing pass
`default_nettype none
module dynamic_priority_scheduler #(
  parameter int MAX_PROCS = dps_pkg::MAX_PROCS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dps_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [dps_pkg::CFG_W-1:0]     cfg_wdata,
  dps_in_if.sink                             in_ch,
  dps_out_if.source                          out_ch
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PROCS - 1);

  // config registers
  logic [dps_pkg::BASE_W-1:0]  base_r;
  logic [dps_pkg::SLICE_W-1:0] slice_r;
  logic [dps_pkg::STEP_W-1:0]  step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= dps_pkg::BASE_RST;
      slice_r <= dps_pkg::SLICE_RST;
      step_r  <= dps_pkg::STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        dps_pkg::REG_BASE:  base_r  <= cfg_wdata;
        dps_pkg::REG_SLICE: slice_r <= cfg_wdata[dps_pkg::SLICE_W-1:0];
        dps_pkg::REG_STEP:  step_r  <= cfg_wdata[dps_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  dps_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic             accept;
  logic             scan_issue;
  logic             out_free;
  logic             commit;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_ch.valid || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dps_pkg::S_IDLE: if (in_ch.valid) state_nxt = dps_pkg::S_SCAN;
      dps_pkg::S_SCAN: if (cnt_r == LAST_IDX) state_nxt = dps_pkg::S_LAST;
      dps_pkg::S_LAST: state_nxt = dps_pkg::S_DONE;
      dps_pkg::S_DONE: if (out_free) state_nxt = dps_pkg::S_IDLE;
      default:         state_nxt = dps_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == dps_pkg::S_IDLE);
    scan_issue  = (state_r == dps_pkg::S_SCAN);
    commit      = (state_r == dps_pkg::S_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dps_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (scan_issue && cnt_r != LAST_IDX) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // held command
  logic        cmd_r;
  logic [7:0]  pid_r;
  logic [15:0] need_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_ch.command;
      pid_r  <= in_ch.process_id;
      need_r <= in_ch.need_time;
    end
  end

  // entry memory and valid bits
  dps_pkg::entry_t  mem [MAX_PROCS];
  dps_pkg::entry_t  rd_r;
  logic [MAX_PROCS-1:0] valid_r;
  logic             beat_r;
  logic             occ_r;
  logic [IDX_W-1:0] beat_idx_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  dps_pkg::entry_t  wr_data;
  logic             set_valid;
  logic             clr_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r       <= mem[cnt_r];
    occ_r      <= valid_r[cnt_r];
    beat_idx_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      beat_r  <= 1'b0;
    end else begin
      beat_r <= scan_issue;
      if (set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

  // shared compare unit
  dps_pkg::pick_ctl_t pick_ctl;
  dps_pkg::pick_st_t  pick_st;
  logic [IDX_W-1:0]   best_idx;
  logic [IDX_W-1:0]   free_idx;
  dps_pkg::entry_t    best;

  assign pick_ctl.start = accept;
  assign pick_ctl.beat  = beat_r;
  assign pick_ctl.occ   = occ_r;

  dps_pick #(
    .MAX_PROCS(MAX_PROCS)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (pick_ctl),
    .beat_idx (beat_idx_r),
    .beat_ent (rd_r),
    .st       (pick_st),
    .best_idx (best_idx),
    .free_idx (free_idx),
    .best_ent (best)
  );

  // slot update
  dps_pkg::status_t   res_status;
  logic [7:0]         res_id;
  logic [15:0]        res_cpu;
  logic [15:0]        res_need;
  logic [15:0]        res_runs;
  logic [15:0]        res_pri;
  logic signed [17:0] pri_init;
  logic signed [17:0] pri_dec;
  logic signed [16:0] pri_sat;
  logic               finish;
  logic [15:0]        charge;
  logic [16:0]        cpu_sum;
  logic [15:0]        cpu_sat;
  logic [15:0]        runs_sat;

  always_comb begin
    pri_init = $signed({3'b000, base_r}) - $signed({2'b00, need_r});
    pri_dec  = $signed({best.pri[16], best.pri}) - $signed({10'd0, step_r});
    pri_sat  = (pri_dec < $signed({dps_pkg::PRI_MIN[16], dps_pkg::PRI_MIN}))
             ? dps_pkg::PRI_MIN : pri_dec[16:0];
    finish   = best.need <= {8'd0, slice_r};
    charge   = finish ? best.need : {8'd0, slice_r};
    cpu_sum  = {1'b0, best.cpu} + {1'b0, charge};
    cpu_sat  = cpu_sum[16] ? 16'hFFFF : cpu_sum[15:0];
    runs_sat = (best.runs == 16'hFFFF) ? best.runs : best.runs + 16'd1;

    res_status = dps_pkg::ST_EMPTY;
    res_id     = '0;
    res_cpu    = '0;
    res_need   = '0;
    res_runs   = '0;
    res_pri    = '0;
    wr_en      = 1'b0;
    wr_addr    = best_idx;
    wr_data    = best;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;

    if (cmd_r == dps_pkg::CMD_ADD) begin
      res_id = pid_r;
      if (!pick_st.free_found) begin
        res_status = dps_pkg::ST_FULL;
      end else begin
        res_status   = dps_pkg::ST_ADDED;
        res_need     = need_r;
        res_pri      = pri_init[15:0];
        wr_en        = commit;
        set_valid    = commit;
        wr_addr      = free_idx;
        wr_data.id   = pid_r;
        wr_data.pri  = pri_init[16:0];
        wr_data.need = need_r;
        wr_data.cpu  = '0;
        wr_data.runs = '0;
      end
    end else if (pick_st.found) begin
      res_id       = best.id;
      res_cpu      = cpu_sat;
      res_runs     = runs_sat;
      wr_en        = commit;
      wr_data.cpu  = cpu_sat;
      wr_data.runs = runs_sat;
      if (finish) begin
        res_status   = dps_pkg::ST_FIN;
        res_pri      = best.pri[15:0];
        wr_data.need = '0;
        clr_valid    = commit;
      end else begin
        res_status   = dps_pkg::ST_RUN;
        res_need     = best.need - {8'd0, slice_r};
        res_pri      = pri_sat[15:0];
        wr_data.need = best.need - {8'd0, slice_r};
        wr_data.pri  = pri_sat;
      end
    end
  end

  // result register
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [7:0]         out_id_r;
  logic [15:0]        out_cpu_r;
  logic [15:0]        out_need_r;
  logic [15:0]        out_runs_r;
  logic signed [15:0] out_pri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status_r <= res_status;
      out_id_r     <= res_id;
      out_cpu_r    <= res_cpu;
      out_need_r   <= res_need;
      out_runs_r   <= res_runs;
      out_pri_r    <= $signed(res_pri);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.chosen_id    = out_id_r;
  assign out_ch.cpu_used     = out_cpu_r;
  assign out_ch.need_left    = out_need_r;
  assign out_ch.run_count    = out_runs_r;
  assign out_ch.new_priority = out_pri_r;

  // checks
`include "dynamic_priority_scheduler_assert.svh"

  `DPS_ASSERT_NEXT(a_busy_after_accept, accept, !in_ch.ready, "ready right after accept")
  `DPS_ASSERT_IMPLY(a_fin_drained, out_ch.valid && out_ch.status == dps_pkg::ST_FIN,
    out_ch.need_left == 16'd0, "finished beat with need left")
  `DPS_ASSERT_IMPLY(a_added_fresh, out_ch.valid && out_ch.status == dps_pkg::ST_ADDED,
    out_ch.cpu_used == 16'd0 && out_ch.run_count == 16'd0, "added beat with history")
  `DPS_ASSERT_IMPLY(a_empty_clean, out_ch.valid && out_ch.status == dps_pkg::ST_EMPTY,
    out_ch.chosen_id == 8'd0 && out_ch.cpu_used == 16'd0, "empty beat with payload")

endmodule
`default_nettype wire
